/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property every clock edge outside reset
`define SWFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that cond implies result in the same cycle
`define SWFE_ASSERT_IMPL(lbl, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (res)) else $error(msg);

// check that cond implies result in the next cycle
`define SWFE_ASSERT_NEXT(lbl, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (res)) else $error(msg);

`endif

/* sv/swfe_pkg.sv */
package swfe_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_req_t;

	typedef struct packed {
		logic [15:0] chunk_bits;
		logic [4:0]  chunk_count;
		logic        frame_end;
	} out_req_t;

	typedef struct packed {
		logic [7:0] data;
		logic       idle;
		logic       cmd_bit;
		logic       gap;
		logic       pad;
		logic [3:0] pad_count;
	} cmd_t;

	localparam logic [6:0] CHUNK_ZERO = 7'h1F;
	localparam logic [6:0] CHUNK_ONE  = 7'h03;
	localparam logic [6:0] CHUNK_HIGH = 7'h7F;
	localparam logic [4:0] WIRE_BITS  = 5'd7;

	localparam logic [2:0] BYTE_IDX_MAX  = 3'd4;
	localparam logic [2:0] BYTE_IDX_READ = 3'd3;
	localparam logic [2:0] PHASE_SHIFT   = 3'd6;
	localparam logic [2:0] PHASE_IDLE    = 3'd1;

	localparam logic [3:0] STEP_IDLE     = 4'd0;
	localparam logic [3:0] STEP_CMD      = 4'd1;
	localparam logic [3:0] STEP_END      = 4'd10;
	localparam logic [3:0] STEP_PAD      = 4'd11;
	localparam logic [3:0] STEP_BIT_BASE = 4'd9;

	localparam int unsigned FIFO_DEPTH = 2;

	function automatic logic [15:0] wire_chunk(input logic one);
		wire_chunk = {9'd0, (one ? CHUNK_ONE : CHUNK_ZERO)};
	endfunction

endpackage

/* sv/single_wire_frame_encoder_top.sv */
// channel | dir | handshake                  | payload
// byte    | in  | byte_valid / byte_stall    | byte_req  (data_byte, first_byte, last_byte)
// chunk   | out | chunk_valid / chunk_stall  | chunk_req (chunk_bits, chunk_count, frame_end)
//
// Each byte yields 10 to 12 chunks, one per cycle from the back sequencer while
// chunk_stall stays low.
// The front classifies a byte in its accept cycle; a two-entry queue holds requests
// until the back is free, and the back loads a waiting one as it emits the last chunk.
// arst_n clears frame state, queue pointers and chunk_valid; no clearing pass is needed.
// chunk_stall holds the output register; byte_stall rises only when the queue is full.
module single_wire_frame_encoder_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  swfe_pkg::in_req_t  byte_req,
	output logic               chunk_valid,
	input  logic               chunk_stall,
	output swfe_pkg::out_req_t chunk_req
);
	import swfe_pkg::*;

	logic fifo_full;
	logic fifo_empty;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	swfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_req   (byte_req),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	swfe_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.pop      (pop),
		.empty    (fifo_empty),
		.pop_cmd  (pop_cmd)
	);

	swfe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (fifo_empty),
		.pop_cmd     (pop_cmd),
		.pop         (pop),
		.chunk_valid (chunk_valid),
		.chunk_stall (chunk_stall),
		.chunk_req   (chunk_req)
	);

endmodule

/* sv/swfe_front.sv */
`include "assert_macros.svh"

module swfe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  swfe_pkg::in_req_t byte_req,
	input  logic              fifo_full,
	output logic              push,
	output swfe_pkg::cmd_t    push_cmd
);
	import swfe_pkg::*;

	logic [2:0] bit_phase_q;
	logic [2:0] byte_index_q;
	logic       read_mode_q;

	logic [2:0] phase_start;
	logic [2:0] phase_end;
	logic [2:0] idx_cur;
	logic       rm_cur;
	logic       rm_next;
	logic [2:0] idx_next;

	assign byte_stall = fifo_full;
	assign push       = byte_valid && !fifo_full;

	always_comb begin
		phase_start = byte_req.first_byte ? PHASE_IDLE : bit_phase_q;
		phase_end   = phase_start + PHASE_SHIFT;
		idx_cur     = byte_req.first_byte ? 3'd0 : byte_index_q;
		rm_cur      = byte_req.first_byte ? 1'b0 : read_mode_q;
		rm_next     = rm_cur || ((idx_cur == BYTE_IDX_READ) && byte_req.data_byte[7]);
		idx_next    = (idx_cur < BYTE_IDX_MAX) ? idx_cur + 3'd1 : idx_cur;

		push_cmd.data      = byte_req.data_byte;
		push_cmd.idle      = byte_req.first_byte;
		push_cmd.cmd_bit   = byte_req.first_byte || byte_req.last_byte;
		push_cmd.gap       = rm_cur && !byte_req.last_byte;
		push_cmd.pad       = byte_req.last_byte;
		push_cmd.pad_count = {1'b1, 3'd0 - phase_end};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_phase_q  <= '0;
			byte_index_q <= '0;
			read_mode_q  <= 1'b0;
		end else if (push) begin
			if (byte_req.last_byte) begin
				bit_phase_q  <= '0;
				byte_index_q <= '0;
				read_mode_q  <= 1'b0;
			end else begin
				bit_phase_q  <= phase_end;
				byte_index_q <= idx_next;
				read_mode_q  <= rm_next;
			end
		end
	end

	`SWFE_ASSERT_NEXT(a_frame_clear, push && byte_req.last_byte, (bit_phase_q == 3'd0) && (byte_index_q == 3'd0) && !read_mode_q, "state not cleared after last byte")
	`SWFE_ASSERT(a_index_sat, byte_index_q <= BYTE_IDX_MAX, "byte index past saturation")

endmodule

/* sv/swfe_fifo.sv */
`include "assert_macros.svh"

module swfe_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  swfe_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output swfe_pkg::cmd_t pop_cmd
);
	import swfe_pkg::*;

	cmd_t       slot_q [FIFO_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'(FIFO_DEPTH));
	assign empty   = (count_q == 2'd0);
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

	`SWFE_ASSERT(a_count_range, count_q <= 2'(FIFO_DEPTH), "queue count overflow")

endmodule

/* sv/swfe_back.sv */
`include "assert_macros.svh"

module swfe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  swfe_pkg::cmd_t     pop_cmd,
	output logic               pop,
	output logic               chunk_valid,
	input  logic               chunk_stall,
	output swfe_pkg::out_req_t chunk_req
);
	import swfe_pkg::*;

	cmd_t       cur_q;
	logic       busy_q;
	logic [3:0] step_q;
	logic       out_valid_q;
	out_req_t   out_q;

	logic       emit;
	logic       last_step;
	out_req_t   chunk;
	logic [2:0] bit_sel;

	assign chunk_valid = out_valid_q;
	assign chunk_req   = out_q;

	assign emit      = busy_q && (!out_valid_q || !chunk_stall);
	assign last_step = (step_q == STEP_PAD) || ((step_q == STEP_END) && !cur_q.pad);
	assign pop       = !empty && (!busy_q || (emit && last_step));
	assign bit_sel   = 3'(STEP_BIT_BASE - step_q);

	always_comb begin
		chunk.chunk_count = WIRE_BITS;
		chunk.frame_end   = 1'b0;
		case (step_q)
			STEP_IDLE: begin
				chunk.chunk_bits  = 16'd1;
				chunk.chunk_count = 5'd1;
			end
			STEP_CMD: begin
				chunk.chunk_bits = wire_chunk(cur_q.cmd_bit);
			end
			STEP_PAD: begin
				chunk.chunk_bits  = 16'hFFFF >> (5'd16 - {1'b0, cur_q.pad_count});
				chunk.chunk_count = {1'b0, cur_q.pad_count};
				chunk.frame_end   = 1'b1;
			end
			default: begin
				if (cur_q.gap) begin
					chunk.chunk_bits = {9'd0, CHUNK_HIGH};
				end else if (step_q == STEP_END) begin
					chunk.chunk_bits = wire_chunk(1'b0);
				end else begin
					chunk.chunk_bits = wire_chunk(cur_q.data[bit_sel]);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_cmd;
		end
		if (emit) begin
			out_q <= chunk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= STEP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= pop_cmd.idle ? STEP_IDLE : STEP_CMD;
			end else if (emit && last_step) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_q + 4'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!chunk_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SWFE_ASSERT_IMPL(a_pad_step, busy_q && (step_q == STEP_PAD), cur_q.pad, "pad step without last byte")
	`SWFE_ASSERT_IMPL(a_step_range, busy_q, step_q <= STEP_PAD, "step out of range")

endmodule
